// ===== sv/kpv_pkg.sv =====
// Package: shared constants, register indices, reset values and sequencer states for the tracker.
`default_nettype none
package kpv_pkg;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int REG_WIDTH      = 31;
	localparam int IDX_WIDTH      = 2;

	localparam logic [IDX_WIDTH-1:0] REG_P0 = 2'd0;
	localparam logic [IDX_WIDTH-1:0] REG_Q  = 2'd1;
	localparam logic [IDX_WIDTH-1:0] REG_R  = 2'd2;

	localparam logic [REG_WIDTH-1:0] P0_RESET = 31'd65536;
	localparam logic [REG_WIDTH-1:0] Q_RESET  = 31'd655;
	localparam logic [REG_WIDTH-1:0] R_RESET  = 31'd65536;

	// sequencer steps; a product issued in one step is read in the next
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_VDT,    // issue v*dt ; t1 = p10+p01
		ST_SUMP,   // pos += v*dt ; issue dt*dt
		ST_DT2,    // t0 = dt*dt ; issue dt*t1
		ST_DT2P,   // n00 = p00 + dt*t1 ; issue t0*p11
		ST_DP,     // n00 += t0*p11 ; issue dt*p11
		ST_N01,    // t0 = dp ; p01 += dp
		ST_N10,    // p10 += dp
		ST_Q00,    // p00 = n00 + q
		ST_Q11,    // p11 += q
		ST_S,      // s = p00 + r
		ST_Y,      // y = z - pos
		ST_DIV0,   // launch k0 divide, or zero gains
		ST_WAIT0,
		ST_DIV1,   // launch k1 divide
		ST_WAIT1,
		ST_KY0,    // issue k0*y ; t1 = 1 - k0
		ST_KY1,    // pos += k0*y ; issue k1*y
		ST_C0,     // vel += k1*y ; issue omk*p00
		ST_C1,     // t0 = omk*p00 ; issue omk*p01
		ST_C2,     // n00 = omk*p01 ; issue k1*p00
		ST_C3,     // p10 -= k1*p00 ; issue k1*p01
		ST_C4,     // p11 -= k1*p01
		ST_DONE
	} kpv_state_t;
endpackage
`default_nettype wire

// ===== sv/kalman_pos_vel_tracker.sv =====
// Top level: register file, sequencer and state of the two-state Kalman tracker.
// Each word (Q16.16 by default) runs from acceptance to result through the steps on
// the shared registered multiplier and adder, plus two bit-serial divides; with a
// zero divisor the divides are skipped.
// in_ready is low while a word is in flight or its result waits on the output, so
// the next word is taken at the earliest in the cycle after the result is taken.
// Writes to the REG_P0 (initial variance) index are ignored: reset loads the
// covariance from the fixed P0_RESET, so such a write has no effect.
`default_nettype none
module kalman_pos_vel_tracker import kpv_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [IDX_WIDTH-1:0] cfg_index,
	input  wire logic [REG_WIDTH-1:0] cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic signed [31:0]   measured_pos,
	input  wire logic [30:0]          time_step,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [31:0]        est_pos,
	output logic signed [31:0]        est_vel,
	output logic                      sat_flag
);
	localparam int W = WORD_WIDTH;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE  = (FRAC_BITS < W-1) ?
		W'(64'd1 << FRAC_BITS) : WMAX;
	localparam logic ONE_OVF = (FRAC_BITS >= W-1);
	localparam logic signed [W-1:0] P0_INIT = (64'(P0_RESET) > 64'(WMAX)) ?
		WMAX : W'(P0_RESET);

	logic [REG_WIDTH-1:0] q_q, r_q;
	kpv_state_t state_q, state_d;
	logic signed [W-1:0] pos_q, vel_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [W-1:0] z_q, dt_q, qn_q, rn_q, t0_q, t1_q, n00_q, s_q, k0_q, k1_q, y_q;
	logic flag_q;
	logic signed [W-1:0] ma, mb, mp;
	logic msat;
	logic signed [W-1:0] dnum;
	logic signed [W-1:0] dq;
	logic dsat;
	logic div_start, div_busy;
	logic signed [W-1:0] add_a, add_b, add_r;
	logic add_sub, add_sat;

	// clamp an unsigned register or field to the word
	function automatic logic signed [W-1:0] clamp_u(input logic [30:0] v);
		if (64'(v) > 64'(WMAX)) return WMAX;
		return W'(v);
	endfunction

	function automatic logic over_u(input logic [30:0] v);
		return 64'(v) > 64'(WMAX);
	endfunction

	function automatic logic signed [W-1:0] clamp_s(input logic signed [31:0] v);
		if (64'(v) > 64'(WMAX)) return WMAX;
		if (64'(v) < 64'(WMIN)) return WMIN;
		return W'(v);
	endfunction

	function automatic logic over_s(input logic signed [31:0] v);
		return (64'(v) > 64'(WMAX)) || (64'(v) < 64'(WMIN));
	endfunction

	// shared saturating adder
	always_comb begin
		logic signed [W:0] ext;
		ext = add_sub ? ((W+1)'(add_a) - (W+1)'(add_b)) : ((W+1)'(add_a) + (W+1)'(add_b));
		add_sat = ext[W] != ext[W-1];
		add_r = add_sat ? (ext[W] ? WMIN : WMAX) : ext[W-1:0];
	end

	kpv_mul #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
		.clk (clk), .a (ma), .b (mb), .p (mp), .sat (msat)
	);

	kpv_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk (clk), .arst_n (arst_n), .start (div_start), .num (dnum), .den (s_q),
		.busy (div_busy), .quo (dq), .sat (dsat)
	);

	// configuration writes; initial variance is fixed by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= Q_RESET;
			r_q <= R_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_P0:  ;
				REG_Q:   q_q <= cfg_data;
				REG_R:   r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = state_q == ST_DONE;
	assign est_pos   = 32'(pos_q);
	assign est_vel   = 32'(vel_q);
	assign sat_flag  = flag_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_VDT;
			ST_VDT:   state_d = ST_SUMP;
			ST_SUMP:  state_d = ST_DT2;
			ST_DT2:   state_d = ST_DT2P;
			ST_DT2P:  state_d = ST_DP;
			ST_DP:    state_d = ST_N01;
			ST_N01:   state_d = ST_N10;
			ST_N10:   state_d = ST_Q00;
			ST_Q00:   state_d = ST_Q11;
			ST_Q11:   state_d = ST_S;
			ST_S:     state_d = ST_Y;
			ST_Y:     state_d = ST_DIV0;
			ST_DIV0:  state_d = (s_q == '0) ? ST_KY0 : ST_WAIT0;
			ST_WAIT0: if (!div_busy) state_d = ST_DIV1;
			ST_DIV1:  state_d = ST_WAIT1;
			ST_WAIT1: if (!div_busy) state_d = ST_KY0;
			ST_KY0:   state_d = ST_KY1;
			ST_KY1:   state_d = ST_C0;
			ST_C0:    state_d = ST_C1;
			ST_C1:    state_d = ST_C2;
			ST_C2:    state_d = ST_C3;
			ST_C3:    state_d = ST_C4;
			ST_C4:    state_d = ST_DONE;
			ST_DONE:  if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// operand select for the multiplier and the divider
	always_comb begin
		ma = '0;
		mb = '0;
		div_start = 1'b0;
		dnum = p00_q;
		unique case (state_q)
			ST_VDT:  begin ma = vel_q; mb = dt_q;  end
			ST_SUMP: begin ma = dt_q;  mb = dt_q;  end
			ST_DT2:  begin ma = dt_q;  mb = t1_q;  end
			ST_DT2P: begin ma = t0_q;  mb = p11_q; end
			ST_DP:   begin ma = dt_q;  mb = p11_q; end
			ST_DIV0: div_start = s_q != '0;
			ST_DIV1: begin div_start = 1'b1; dnum = p10_q; end
			ST_KY0:  begin ma = k0_q; mb = y_q;   end
			ST_KY1:  begin ma = k1_q; mb = y_q;   end
			ST_C0:   begin ma = t1_q; mb = p00_q; end
			ST_C1:   begin ma = t1_q; mb = p01_q; end
			ST_C2:   begin ma = k1_q; mb = p00_q; end
			ST_C3:   begin ma = k1_q; mb = p01_q; end
			default: ;
		endcase
	end

	// adder operand select
	always_comb begin
		add_a = '0;
		add_b = '0;
		add_sub = 1'b0;
		unique case (state_q)
			ST_VDT:  begin add_a = p10_q; add_b = p01_q; end
			ST_SUMP: begin add_a = pos_q; add_b = mp; end
			ST_DT2P: begin add_a = p00_q; add_b = mp; end
			ST_DP:   begin add_a = n00_q; add_b = mp; end
			ST_N01:  begin add_a = p01_q; add_b = mp; end
			ST_N10:  begin add_a = p10_q; add_b = t0_q; end
			ST_Q00:  begin add_a = n00_q; add_b = qn_q; end
			ST_Q11:  begin add_a = p11_q; add_b = qn_q; end
			ST_S:    begin add_a = p00_q; add_b = rn_q; end
			ST_Y:    begin add_a = z_q;   add_b = pos_q; add_sub = 1'b1; end
			ST_KY0:  begin add_a = ONE;   add_b = k0_q;  add_sub = 1'b1; end
			ST_KY1:  begin add_a = pos_q; add_b = mp; end
			ST_C0:   begin add_a = vel_q; add_b = mp; end
			ST_C3:   begin add_a = p10_q; add_b = mp; add_sub = 1'b1; end
			ST_C4:   begin add_a = p11_q; add_b = mp; add_sub = 1'b1; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// datapath registers, one step per state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			vel_q  <= '0;
			p00_q  <= P0_INIT;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= P0_INIT;
			flag_q <= 1'b0;
			z_q    <= '0;
			dt_q   <= '0;
			qn_q   <= '0;
			rn_q   <= '0;
			t0_q   <= '0;
			t1_q   <= '0;
			n00_q  <= '0;
			s_q    <= '0;
			k0_q   <= '0;
			k1_q   <= '0;
			y_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					z_q    <= clamp_s(measured_pos);
					dt_q   <= clamp_u(time_step);
					qn_q   <= clamp_u(q_q);
					rn_q   <= clamp_u(r_q);
					flag_q <= over_s(measured_pos) | over_u(time_step) | over_u(q_q) |
						over_u(r_q) | ONE_OVF;
				end
				ST_VDT: begin
					t1_q   <= add_r;
					flag_q <= flag_q | add_sat;
				end
				ST_SUMP: begin
					pos_q  <= add_r;
					flag_q <= flag_q | msat | add_sat;
				end
				ST_DT2: begin
					t0_q   <= mp;
					flag_q <= flag_q | msat;
				end
				ST_DT2P, ST_DP: begin
					n00_q  <= add_r;
					flag_q <= flag_q | msat | add_sat;
				end
				ST_N01: begin
					t0_q   <= mp;
					p01_q  <= add_r;
					flag_q <= flag_q | msat | add_sat;
				end
				ST_N10: begin
					p10_q  <= add_r;
					flag_q <= flag_q | add_sat;
				end
				ST_Q00: begin
					p00_q  <= add_r;
					flag_q <= flag_q | add_sat;
				end
				ST_Q11: begin
					p11_q  <= add_r;
					flag_q <= flag_q | add_sat;
				end
				ST_S: begin
					s_q    <= add_r;
					flag_q <= flag_q | add_sat;
				end
				ST_Y: begin
					y_q    <= add_r;
					flag_q <= flag_q | add_sat;
				end
				// zero divisor: drop both gains
				ST_DIV0: if (s_q == '0) begin
					k0_q   <= '0;
					k1_q   <= '0;
					flag_q <= 1'b1;
				end
				ST_WAIT0: if (!div_busy) begin
					k0_q   <= dq;
					flag_q <= flag_q | dsat;
				end
				ST_WAIT1: if (!div_busy) begin
					k1_q   <= dq;
					flag_q <= flag_q | dsat;
				end
				ST_KY0: begin
					t1_q   <= add_r;
					flag_q <= flag_q | add_sat;
				end
				ST_KY1: begin
					pos_q  <= add_r;
					flag_q <= flag_q | msat | add_sat;
				end
				ST_C0: begin
					vel_q  <= add_r;
					flag_q <= flag_q | msat | add_sat;
				end
				ST_C1: begin
					t0_q   <= mp;
					flag_q <= flag_q | msat;
				end
				ST_C2: begin
					n00_q  <= mp;
					flag_q <= flag_q | msat;
				end
				ST_C3: begin
					p10_q  <= add_r;
					p00_q  <= t0_q;
					flag_q <= flag_q | msat | add_sat;
				end
				ST_C4: begin
					p11_q  <= add_r;
					p01_q  <= n00_q;
					flag_q <= flag_q | msat | add_sat;
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("ready while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_WAIT0 || state_q == ST_WAIT1))
		else $error("divider busy outside wait");
endmodule
`default_nettype wire

// ===== sv/kpv_mul.sv =====
// Shared fixed-point multiplier: product, floor shift by FRAC_BITS, saturation.
`default_nettype none
module kpv_mul import kpv_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic signed [WORD_WIDTH-1:0] a,
	input  wire logic signed [WORD_WIDTH-1:0] b,
	output logic signed [WORD_WIDTH-1:0]      p,
	output logic                              sat
);
	localparam int PW = 2 * WORD_WIDTH;
	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] shifted;
	logic signed [PW-1:0] wmax;
	logic signed [PW-1:0] wmin;

	// register the raw product, then shift and clamp
	always_ff @(posedge clk) begin
		prod_s1 <= PW'(a) * PW'(b);
	end

	always_comb begin
		shifted = prod_s1 >>> FRAC_BITS;
		wmax = PW'({1'b0, {(WORD_WIDTH-1){1'b1}}});
		wmin = ~wmax;
		sat = 1'b0;
		if (shifted > wmax) begin
			p = wmax[WORD_WIDTH-1:0];
			sat = 1'b1;
		end else if (shifted < wmin) begin
			p = wmin[WORD_WIDTH-1:0];
			sat = 1'b1;
		end else begin
			p = shifted[WORD_WIDTH-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== sv/kpv_div.sv =====
// Serial restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
`default_nettype none
module kpv_div import kpv_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [WORD_WIDTH-1:0] num,
	input  wire logic signed [WORD_WIDTH-1:0] den,
	output logic                              busy,
	output logic signed [WORD_WIDTH-1:0]      quo,
	output logic                              sat
);
	localparam int NW = WORD_WIDTH + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0]          dividend_q;
	logic [NW-1:0]          quot_q;
	logic [WORD_WIDTH:0]    rem_q;
	logic [WORD_WIDTH-1:0]  dmag_q;
	logic                   neg_q;
	logic [CW-1:0]          cnt_q;
	logic [WORD_WIDTH:0]    trial;
	logic [WORD_WIDTH:0]    diff;
	logic [WORD_WIDTH-1:0]  nmag;
	logic [WORD_WIDTH-1:0]  dmag;
	logic [NW-1:0]          lim;

	assign nmag = num[WORD_WIDTH-1] ? WORD_WIDTH'(-num) : WORD_WIDTH'(num);
	assign dmag = den[WORD_WIDTH-1] ? WORD_WIDTH'(-den) : WORD_WIDTH'(den);
	assign trial = {rem_q[WORD_WIDTH-1:0], dividend_q[NW-1]};
	assign diff = trial - {1'b0, dmag_q};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy  <= 1'b0;
		end else if (start) begin
			cnt_q <= CW'(NW);
			busy  <= 1'b1;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= {nmag, {FRAC_BITS{1'b0}}};
			quot_q     <= '0;
			rem_q      <= '0;
			dmag_q     <= dmag;
			neg_q      <= num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1];
		end else if (busy) begin
			dividend_q <= dividend_q << 1;
			if (!diff[WORD_WIDTH]) begin
				rem_q  <= diff;
				quot_q <= {quot_q[NW-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[NW-2:0], 1'b0};
			end
		end
	end

	// clamp magnitude to the word range by sign
	always_comb begin
		lim = neg_q ? NW'({1'b1, {(WORD_WIDTH-1){1'b0}}})
		            : NW'({1'b0, {(WORD_WIDTH-1){1'b1}}});
		sat = 1'b0;
		if (quot_q > lim) begin
			sat = 1'b1;
			quo = neg_q ? {1'b1, {(WORD_WIDTH-1){1'b0}}} : {1'b0, {(WORD_WIDTH-1){1'b1}}};
		end else begin
			quo = neg_q ? WORD_WIDTH'(-quot_q) : quot_q[WORD_WIDTH-1:0];
		end
	end
endmodule
`default_nettype wire
